/* rtl/assert_macros.svh */
// Assertion macros used by the top level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/jlim_pkg.sv */
// Types, constants and helpers of the joint limit avoidance velocity unit
package jlim_pkg;

	localparam int LOG_ITER_DEF = 24;
	localparam int DIV_BITS     = 31;
	localparam int FRAC_W       = 40;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [31:0] VEL_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] VEL_MIN = 32'h8000_0000;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_LIMIT = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] lim_lo;
		logic signed [31:0] lim_hi;
		logic        [31:0] gain;
		logic               last_joint;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] velocity;
		logic        [1:0]  status;
		logic               last_out;
	} res_t;

	typedef struct packed {
		logic [31:0]       gain;
		logic              last;
		logic [1:0]        status;
		logic              e_pos;
		logic              e_neg;
		logic              special;
		logic [31:0]       vel_special;
		logic [33:0]       a;
		logic [33:0]       b;
		logic [5:0]        ka;
		logic [5:0]        kb;
		logic [30:0]       ma;
		logic [30:0]       mb;
		logic [FRAC_W-1:0] fa;
		logic [FRAC_W-1:0] fb;
		logic [45:0]       dmag;
		logic [31:0]       lmag;
		logic [63:0]       p;
		logic [66:0]       ra;
		logic [66:0]       rb;
		logic [30:0]       qa;
		logic [30:0]       qb;
		logic              sata;
		logic              satb;
	} pipe_t;

	// position of the leading one
	function automatic logic [5:0] lead_one(input logic [33:0] x);
		logic [5:0] k;
		k = 6'd0;
		for (int i = 0; i < 34; i++) begin
			if (x[i]) k = 6'(i);
		end
		return k;
	endfunction

	// mantissa in Q1.30, low bits of larger values dropped
	function automatic logic [30:0] norm_q30(input logic [33:0] x, input logic [5:0] k);
		logic [63:0] w;
		if (k <= 6'd30) w = 64'(x) << (6'd30 - k);
		else w = 64'(x) >> (k - 6'd30);
		return w[30:0];
	endfunction

endpackage

/* rtl/jlim_log_cell.sv */
// One squaring step of the log2 iteration, both lanes
module jlim_log_cell #(
	parameter int STEP = 1
) (
	input  logic           clk,
	input  logic           en,
	input  jlim_pkg::pipe_t d,
	output jlim_pkg::pipe_t cell_q
);
	localparam int FBIT = jlim_pkg::FRAC_W - STEP;

	logic [61:0] sq_a, sq_b;
	jlim_pkg::pipe_t nxt;

	always_comb begin
		nxt  = d;
		sq_a = 62'(d.ma) * 62'(d.ma);
		sq_b = 62'(d.mb) * 62'(d.mb);
		// keep the mantissa below two, one fraction bit per step
		if (sq_a[61]) begin
			nxt.ma = sq_a[61:31];
			nxt.fa[FBIT] = 1'b1;
		end else begin
			nxt.ma = sq_a[60:30];
		end
		if (sq_b[61]) begin
			nxt.mb = sq_b[61:31];
			nxt.fb[FBIT] = 1'b1;
		end else begin
			nxt.mb = sq_b[60:30];
		end
	end

	always_ff @(posedge clk) begin
		if (en) cell_q <= nxt;
	end
endmodule

/* rtl/jlim_div_cell.sv */
// One restoring quotient bit of both divisions
module jlim_div_cell #(
	parameter int SHIFT = 0
) (
	input  logic           clk,
	input  logic           en,
	input  jlim_pkg::pipe_t d,
	output jlim_pkg::pipe_t cell_q
);
	logic [66:0] da, db;
	jlim_pkg::pipe_t nxt;

	always_comb begin
		nxt = d;
		da  = 67'(d.a) << SHIFT;
		db  = 67'(d.b) << SHIFT;
		if (d.ra >= da) begin
			nxt.ra = d.ra - da;
			nxt.qa[SHIFT] = 1'b1;
		end
		if (d.rb >= db) begin
			nxt.rb = d.rb - db;
			nxt.qb[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) cell_q <= nxt;
	end
endmodule

/* rtl/joint_limit_avoidance_velocity_unit.sv */
// Top level of the joint limit avoidance velocity unit
//
//  channel  direction  payload              handshake
//  cmd      in         jlim_pkg::cmd_t      cmd_valid / cmd_ready
//  res      out        jlim_pkg::res_t      res_valid / res_ready
//
// One joint enters per cycle unless the result side stalls. Each result passes
// through the row of log cells (one squaring each) and the row of 31 division
// cells (one quotient bit each) on its way to the output register.
// Reset clears only the stage valid bits; no clearing pass is needed.
// A stalled result holds the whole row: every cell advances only while the
// output register is empty or being taken.
`include "assert_macros.svh"

module joint_limit_avoidance_velocity_unit #(
	parameter int LOG_ITERATIONS = jlim_pkg::LOG_ITER_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  jlim_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output jlim_pkg::res_t res
);
	localparam int NDIV   = jlim_pkg::DIV_BITS;
	localparam int NSTAGE = LOG_ITERATIONS + NDIV + 7;

	logic              en;
	logic [NSTAGE-1:0] valid_q;

	jlim_pkg::pipe_t prep_s1, prep_c;
	jlim_pkg::pipe_t norm_s2, norm_c;
	jlim_pkg::pipe_t log_s [0:LOG_ITERATIONS];
	jlim_pkg::pipe_t diff_s3, diff_c, lmag_s4, lmag_c, prod_s5, prod_c;
	jlim_pkg::pipe_t seed_s6, seed_c;
	jlim_pkg::pipe_t div_s [0:NDIV];
	jlim_pkg::res_t  res_q;

	// advance the whole row whenever the output slot frees up
	assign en        = !valid_q[NSTAGE-1] || res_ready;
	assign cmd_ready = en;
	assign res_valid = valid_q[NSTAGE-1];
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[NSTAGE-2:0], cmd_valid};
		end
	end

	// input stage: error, range and the special cases
	logic signed [34:0] e_w, r_w, a_w, b_w;
	always_comb begin
		prep_c = '0;
		e_w = (35'(cmd.position) <<< 1) - 35'(cmd.lim_lo) - 35'(cmd.lim_hi);
		r_w = 35'(cmd.lim_hi) - 35'(cmd.lim_lo);
		a_w = r_w + e_w;
		b_w = r_w - e_w;
		prep_c.gain  = cmd.gain;
		prep_c.last  = cmd.last_joint;
		prep_c.e_pos = (e_w > 35'sd0);
		prep_c.e_neg = e_w[34];
		prep_c.a     = a_w[33:0];
		prep_c.b     = b_w[33:0];
		if (prep_c.e_pos) prep_c.vel_special = jlim_pkg::VEL_MIN;
		else if (prep_c.e_neg) prep_c.vel_special = jlim_pkg::VEL_MAX;
		else prep_c.vel_special = 32'd0;
		if (r_w <= 35'sd0) begin
			prep_c.status  = jlim_pkg::ST_RANGE;
			prep_c.special = 1'b1;
		end else if (e_w >= r_w || -e_w >= r_w) begin
			prep_c.status  = jlim_pkg::ST_LIMIT;
			prep_c.special = 1'b1;
		end else begin
			prep_c.status  = jlim_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en) prep_s1 <= prep_c;
	end

	// normalise both operands to Q1.30
	always_comb begin
		norm_c    = prep_s1;
		norm_c.ka = jlim_pkg::lead_one(prep_s1.a);
		norm_c.kb = jlim_pkg::lead_one(prep_s1.b);
		norm_c.ma = jlim_pkg::norm_q30(prep_s1.a, norm_c.ka);
		norm_c.mb = jlim_pkg::norm_q30(prep_s1.b, norm_c.kb);
	end

	always_ff @(posedge clk) begin
		if (en) norm_s2 <= norm_c;
	end

	assign log_s[0] = norm_s2;

	for (genvar i = 0; i < LOG_ITERATIONS; i++) begin : g_log
		jlim_log_cell #(.STEP(i + 1)) u_cell (
			.clk    (clk),
			.en     (en),
			.d      (log_s[i]),
			.cell_q (log_s[i+1])
		);
	end

	// difference of the two logs, then its magnitude
	logic [46:0] d_w;
	assign d_w = {1'b0, log_s[LOG_ITERATIONS].ka, log_s[LOG_ITERATIONS].fa}
	           - {1'b0, log_s[LOG_ITERATIONS].kb, log_s[LOG_ITERATIONS].fb};

	always_comb begin
		diff_c      = log_s[LOG_ITERATIONS];
		diff_c.dmag = d_w[46] ? 46'(-d_w) : d_w[45:0];
	end

	always_ff @(posedge clk) begin
		if (en) diff_s3 <= diff_c;
	end

	// scale log2 to natural log
	logic [63:0] ln_w, p_w;
	assign ln_w = 64'(diff_s3.dmag[45:14]) * 64'(jlim_pkg::LN2_Q32);

	always_comb begin
		lmag_c      = diff_s3;
		lmag_c.lmag = ln_w[63:32];
	end

	always_ff @(posedge clk) begin
		if (en) lmag_s4 <= lmag_c;
	end

	assign p_w = 64'(lmag_s4.gain) * 64'(lmag_s4.lmag);

	always_comb begin
		prod_c   = lmag_s4;
		prod_c.p = p_w;
	end

	always_ff @(posedge clk) begin
		if (en) prod_s5 <= prod_c;
	end

	// saturation test, then seed the division row with 8*P
	logic [66:0] n8_w;
	assign n8_w = {prod_s5.p, 3'b000};

	always_comb begin
		seed_c      = prod_s5;
		seed_c.ra   = n8_w;
		seed_c.rb   = n8_w;
		seed_c.qa   = '0;
		seed_c.qb   = '0;
		seed_c.sata = (n8_w >= (67'(prod_s5.a) << NDIV));
		seed_c.satb = (n8_w >= (67'(prod_s5.b) << NDIV));
	end

	always_ff @(posedge clk) begin
		if (en) seed_s6 <= seed_c;
	end

	assign div_s[0] = seed_s6;

	for (genvar j = 0; j < NDIV; j++) begin : g_div
		jlim_div_cell #(.SHIFT(NDIV - 1 - j)) u_cell (
			.clk    (clk),
			.en     (en),
			.d      (div_s[j]),
			.cell_q (div_s[j+1])
		);
	end

	// sum the terms, cap, apply sign, the special cases and zero gain
	jlim_pkg::pipe_t fin;
	logic [31:0] ta_w, tb_w, m_w, vel_w;
	logic [32:0] sum_w;
	assign fin = div_s[NDIV];

	always_comb begin
		ta_w  = fin.sata ? 32'h8000_0000 : {1'b0, fin.qa};
		tb_w  = fin.satb ? 32'h8000_0000 : {1'b0, fin.qb};
		sum_w = 33'(ta_w) + 33'(tb_w);
		m_w   = (sum_w > 33'h0_8000_0000) ? 32'h8000_0000 : sum_w[31:0];
		if (fin.special) vel_w = fin.vel_special;
		else if (fin.e_pos) vel_w = 32'd0 - m_w;
		else if (fin.e_neg) vel_w = (m_w > jlim_pkg::VEL_MAX) ? jlim_pkg::VEL_MAX : m_w;
		else vel_w = 32'd0;
		if (fin.gain == 32'd0) vel_w = 32'd0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.velocity <= vel_w;
			res_q.status   <= fin.status;
			res_q.last_out <= fin.last;
		end
	end

	// saturated or zero velocity, as every special case gives
	logic sat_vel_w;
	assign sat_vel_w = res.velocity == jlim_pkg::VEL_MIN || res.velocity == jlim_pkg::VEL_MAX
	                || res.velocity == 32'd0;

	`ASSERT_IMPLIES(a_status_code, clk, arst_n, res_valid, res.status <= jlim_pkg::ST_RANGE)
	`ASSERT_IMPLIES(a_range_sat, clk, arst_n, res_valid && res.status == jlim_pkg::ST_RANGE, sat_vel_w)
	`ASSERT_IMPLIES(a_limit_sat, clk, arst_n, res_valid && res.status == jlim_pkg::ST_LIMIT, sat_vel_w)

endmodule

/* sim/tb_joint_limit_avoidance_velocity_unit.sv */
// Testbench of the joint limit avoidance velocity unit with a predicting scoreboard
`timescale 1ns / 1ps

module tb_joint_limit_avoidance_velocity_unit;

	localparam int LOG_ITER    = 24;
	localparam int LATENCY     = LOG_ITER + 38;
	localparam int N_RANDOM    = 1600;
	localparam int CYCLE_LIMIT = 400000;

	// Expected velocities of accepted joints, oldest first, and the
	// arithmetic that produces them.
	class joint_velocity_board;
		jlim_pkg::res_t pending_velocities[$];
		int   fails;
		int   mismatches;

		// log2 of x (x >= 1) in Q.40 via repeated squaring
		function longint unsigned log2_q40(longint unsigned x);
			int k;
			longint unsigned t, m, frac;
			k = 0;
			t = x;
			frac = 0;
			while (t > 1) begin
				t >>= 1;
				k++;
			end
			if (k <= 30) m = x << (30 - k);
			else m = x >> (k - 30);
			for (int i = 1; i <= LOG_ITER; i++) begin
				m = (m * m) >> 30;
				if (m >= (64'd2 << 30)) begin
					m >>= 1;
					frac |= 64'd1 << (40 - i);
				end
			end
			return (longint'(k) << 40) | frac;
		endfunction

		// floor(8*p/d), clipped at 2^31
		function longint unsigned scaled_quotient(longint unsigned p, longint unsigned d);
			longint unsigned q, r, t;
			q = p / d;
			r = p % d;
			if (q >= (64'd1 << 28)) return 64'd1 << 31;
			t = 8 * q + (8 * r) / d;
			if (t > (64'd1 << 31)) t = 64'd1 << 31;
			return t;
		endfunction

		function jlim_pkg::res_t velocity_for(jlim_pkg::cmd_t c);
			longint pos, lo, hi, e, r, d;
			longint unsigned a, b, dmag, lmag, p, m;
			jlim_pkg::res_t o;
			pos = c.position;
			lo = c.lim_lo;
			hi = c.lim_hi;
			e = 2 * pos - lo - hi;
			r = hi - lo;
			o.last_out = c.last_joint;
			if (r <= 0 || e >= r || -e >= r) begin
				// saturate toward the mean when out of range or limits are bad
				o.status = (r <= 0) ? jlim_pkg::ST_RANGE : jlim_pkg::ST_LIMIT;
				o.velocity = (e > 0) ? jlim_pkg::VEL_MIN :
					(e < 0) ? jlim_pkg::VEL_MAX : 32'd0;
			end else begin
				a = r + e;
				b = r - e;
				d = longint'(log2_q40(a)) - longint'(log2_q40(b));
				dmag = (d < 0) ? -d : d;
				lmag = ((dmag >> 14) * jlim_pkg::LN2_Q32) >> 32;
				p = c.gain * lmag;
				m = scaled_quotient(p, a) + scaled_quotient(p, b);
				if (m > (64'd1 << 31)) m = 64'd1 << 31;
				o.status = jlim_pkg::ST_OK;
				if (e > 0) o.velocity = 32'(64'd0 - m);
				else if (e < 0) o.velocity = (m > jlim_pkg::VEL_MAX) ? jlim_pkg::VEL_MAX : 32'(m);
				else o.velocity = 32'd0;
			end
			if (c.gain == 0) o.velocity = 32'd0;
			return o;
		endfunction

		function void note_command(jlim_pkg::cmd_t c);
			pending_velocities.push_back(velocity_for(c));
		endfunction

		function void check_velocity(jlim_pkg::res_t got);
			jlim_pkg::res_t want;
			if (pending_velocities.size() == 0) begin
				fails++;
				if (mismatches++ < 10)
					$display("unexpected result %h", got);
				return;
			end
			want = pending_velocities.pop_front();
			if (got.velocity !== want.velocity || got.status !== want.status ||
					got.last_out !== want.last_out) begin
				fails++;
				if (mismatches++ < 10)
					$display("mismatch: velocity exp %h act %h,",
						want.velocity, got.velocity,
						" status exp %0d act %0d, last exp %b act %b",
						want.status, got.status, want.last_out, got.last_out);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	jlim_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	jlim_pkg::res_t res;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int cycles = 0;
	joint_velocity_board board = new();

	joint_limit_avoidance_velocity_unit #(.LOG_ITERATIONS(LOG_ITER)) dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side at the rate of the current phase.
	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Note every input transfer and check every output transfer.
	always @(posedge clk) begin
		if (arst_n && cmd_valid && cmd_ready) board.note_command(cmd);
		if (arst_n && res_valid && res_ready) board.check_velocity(res);
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offer one joint, idling first at the phase's rate; hold until transfer.
	task automatic send_joint(input jlim_pkg::cmd_t c);
		while ($urandom_range(99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
	endtask

	task automatic send_directed(input logic [31:0] pos, input logic [31:0] lo,
			input logic [31:0] hi, input logic [31:0] g, input logic last);
		jlim_pkg::cmd_t c;
		c.position = pos;
		c.lim_lo = lo;
		c.lim_hi = hi;
		c.gain = g;
		c.last_joint = last;
		send_joint(c);
	endtask

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2, 3: return $urandom;
			default: return $urandom >> $urandom_range(31);
		endcase
	endfunction

	// Mostly joints inside their limits, with some at or past a limit,
	// some with bad limits and some entirely random.
	function automatic jlim_pkg::cmd_t random_joint();
		jlim_pkg::cmd_t c;
		longint lo, span, hi, pos;
		int kind;
		kind = $urandom_range(9);
		c = {$urandom, $urandom, $urandom, $urandom, 1'($urandom)};
		c.gain = (kind == 0) ? $urandom : pick_gain();
		if (kind == 0) return c;
		if (kind == 1) begin
			// high not above low
			if (c.lim_hi > c.lim_lo) c.lim_hi = c.lim_lo - $urandom_range(3);
			if ($urandom_range(3) == 0) c.lim_hi = c.lim_lo;
			return c;
		end
		lo = c.lim_lo;
		span = longint'($urandom >> $urandom_range(31)) + 1;
		if (lo + span > 32'sh7FFF_FFFF) lo = 32'sh7FFF_FFFF - span;
		hi = lo + span;
		if (kind == 2) begin
			// at or past a limit
			case ($urandom_range(3))
				0: pos = lo;
				1: pos = hi;
				2: pos = lo - $urandom_range(1000);
				default: pos = hi + $urandom_range(1000);
			endcase
			if (pos < -64'sd2147483648) pos = -64'sd2147483648;
			if (pos > 64'sd2147483647) pos = 64'sd2147483647;
		end else if (span >= 2) begin
			case ($urandom_range(5))
				0: pos = lo + 1;
				1: pos = hi - 1;
				default: pos = lo + 1 + longint'($urandom) % (span - 1);
			endcase
		end else begin
			pos = lo;
		end
		c.lim_lo = 32'(lo);
		c.lim_hi = 32'(hi);
		c.position = 32'(pos);
		return c;
	endfunction

	task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) send_joint(random_joint());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full range, extremes, mean, limits, bad limits, gains
		send_directed(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_directed(32'h7FFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_directed(32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_directed(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b1);
		send_directed(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0);
		send_directed(32'h0000_0001, 32'h0000_0000, 32'h0000_0002, 32'h0001_0000, 1'b1);
		send_directed(32'h1000_0000, 32'hF000_0000, 32'h3000_0000, 32'h0001_0000, 1'b0);
		send_directed(32'h2FFF_FFFF, 32'hF000_0000, 32'h3000_0000, 32'h0001_0000, 1'b0);
		send_directed(32'hF000_0001, 32'hF000_0000, 32'h3000_0000, 32'h0001_0000, 1'b1);
		send_directed(32'h3000_0000, 32'hF000_0000, 32'h3000_0000, 32'h0001_0000, 1'b0);
		send_directed(32'hF000_0000, 32'hF000_0000, 32'h3000_0000, 32'h0001_0000, 1'b0);
		send_directed(32'h7FFF_FFFF, 32'hF000_0000, 32'h3000_0000, 32'h0001_0000, 1'b1);
		send_directed(32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 32'h0001_0000, 1'b0);
		send_directed(32'h2000_0000, 32'h3000_0000, 32'h1000_0000, 32'h0001_0000, 1'b1);
		send_directed(32'h8000_0000, 32'h3000_0000, 32'h1000_0000, 32'h0001_0000, 1'b0);
		send_directed(32'h2000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		send_directed(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
		send_directed(32'h2FFF_FFFF, 32'hF000_0000, 32'h3000_0000, 32'h0000_0000, 1'b0);
		send_directed(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
		send_directed(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 1'b0);

		run_phase(0, 0, N_RANDOM / 4);
		run_phase(45, 0, N_RANDOM / 4);
		run_phase(0, 45, N_RANDOM / 4);
		run_phase(30, 30, N_RANDOM / 4);
		cmd_valid <= 1'b0;

		// drain, then give the pipeline time to show any stray result
		while (board.pending_velocities.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);

		board.fails += board.pending_velocities.size();
		if (board.fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
